FILE: src/median_filter_3x3_stream_defines.svh
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_STREAM_DEFINES_SVH
`define MEDIAN_FILTER_3X3_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define MF3_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
// Same-cycle implication.
`define MF3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MF3_ASSERT(lbl, cond, msg)
`define MF3_ASSERT_IMP(lbl, ante, cons, msg)
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/mf3_pkg.sv
// Types and constants shared by the 3x3 median filter modules.
package mf3_pkg;

    // Pixel and channel layout.
    localparam int CH_W        = 8;
    localparam int PORT_CH     = 3;
    localparam int PIX_W       = CH_W * PORT_CH;
    localparam int ROW_W       = 12;

    // Window geometry.
    localparam int WIN_TAPS    = 9;
    localparam int WIN_REGS    = 6;

    // Configuration port.
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int FW_RESET    = 640;
    localparam int FH_RESET    = 480;
    localparam int MIN_DIM     = 3;

    // Result queue: up to three results per item.
    localparam int RES_LANES   = 3;
    localparam int RES_DEPTH   = 8;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [PIX_W-1:0] pix_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 4'd0,
        CFG_FRAME_HEIGHT = 4'd1
    } cfg_reg_t;

endpackage

FILE: src/mf3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/mf3_median9.sv
// Median of nine 8-bit values through a fixed compare network.
module mf3_median9 (
    input  logic [mf3_pkg::WIN_TAPS-1:0][mf3_pkg::CH_W-1:0] win,
    output mf3_pkg::chan_t                                   med
);

    mf3_pkg::chan_t col_lo  [3];
    mf3_pkg::chan_t col_mid [3];
    mf3_pkg::chan_t col_hi  [3];
    mf3_pkg::chan_t max_lo;
    mf3_pkg::chan_t med_mid;
    mf3_pkg::chan_t min_hi;

    function automatic mf3_pkg::chan_t min2(input mf3_pkg::chan_t a, input mf3_pkg::chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::chan_t max2(input mf3_pkg::chan_t a, input mf3_pkg::chan_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::chan_t med3(input mf3_pkg::chan_t a, input mf3_pkg::chan_t b,
                                            input mf3_pkg::chan_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Sort each column of three, then take the median of the extremes and middles.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            col_lo[i]  = min2(min2(win[3*i], win[3*i+1]), win[3*i+2]);
            col_mid[i] = med3(win[3*i], win[3*i+1], win[3*i+2]);
            col_hi[i]  = max2(max2(win[3*i], win[3*i+1]), win[3*i+2]);
        end
        max_lo  = max2(max2(col_lo[0], col_lo[1]), col_lo[2]);
        med_mid = med3(col_mid[0], col_mid[1], col_mid[2]);
        min_hi  = min2(min2(col_hi[0], col_hi[1]), col_hi[2]);
        med     = med3(max_lo, med_mid, min_hi);
    end

endmodule

FILE: src/mf3_res_fifo.sv
// Result queue: takes up to LANES results per cycle in lane order; one leaves per pop.
module mf3_res_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int LANES = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [LANES-1:0]                 push_en,
    input  logic [LANES-1:0][WIDTH-1:0]      push_data,
    input  logic                             pop,
    output logic                             out_valid,
    output logic [WIDTH-1:0]                 out_data,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] lane_off [LANES];
    logic [SUM_W-1:0] push_total;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [SUM_W-1:0] k);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + k;
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // Slot offset of each lane: the number of active lanes before it.
    always_comb begin
        push_total = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_off[i] = push_total;
            push_total  = push_total + SUM_W'(push_en[i]);
        end
    end

    assign do_pop = pop && (count_reg != '0);

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wrap_add(wr_ptr_reg, push_total);
        rd_ptr_next = do_pop ? wrap_add(rd_ptr_reg, SUM_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_total) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage: active lanes land in consecutive slots.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            if (push_en[i]) begin
                mem[wrap_add(wr_ptr_reg, lane_off[i])] <= push_data[i];
            end
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: src/median_filter_3x3_stream.sv
// Top level of the streaming 3x3 median filter over three 8-bit channels.
//
// Pixels enter on the s_ channel in raster order, one item per handshake, and
// filtered pixels leave on the m_ channel with their row and column attached.
// Each channel is filtered on its own; interior pixels get the median of their
// 3x3 neighborhood and border pixels pass through. Results are not in raster
// order: input (r,c) yields pixel (r-1,c-1), plus (r-1,last column) at the end
// of a row and (r,c) on the last row. m_last_of_run marks the last result of
// an item. Frame size is set over the cfg_ port; the user must write it only
// while the block is idle, which is not enforced. Throughput is one item per
// cycle while s_ready is high; an item's line store read is issued as it is
// taken and filtered in the filter stage. The result queue holds eight entries;
// s_ready drops only while it could not take the three results of another
// item, so a stalled receiver stops input after a few items and no result is
// ever lost. Reset clears the row and column counters, the window and the queue
// and sets the frame to 640 by 480; the line store RAM needs no clearing.
module median_filter_3x3_stream #(
    parameter int MAX_WIDTH    = 2048,
    parameter int NUM_CHANNELS = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Pixel input channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mf3_pkg::CH_W-1:0]           s_in_ch0,
    input  logic [mf3_pkg::CH_W-1:0]           s_in_ch1,
    input  logic [mf3_pkg::CH_W-1:0]           s_in_ch2,
    // Result channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mf3_pkg::CH_W-1:0]           m_out_ch0,
    output logic [mf3_pkg::CH_W-1:0]           m_out_ch1,
    output logic [mf3_pkg::CH_W-1:0]           m_out_ch2,
    output logic [mf3_pkg::ROW_W-1:0]          m_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]       m_out_col,
    output logic                               m_last_of_run
);

`include "median_filter_3x3_stream_defines.svh"

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int RW      = mf3_pkg::ROW_W;
    localparam int CW      = mf3_pkg::CFG_DATA_W;
    localparam int PW      = mf3_pkg::PIX_W;
    localparam int CHW     = mf3_pkg::CH_W;
    localparam int CMP_W   = (COL_W + 1 > CW) ? COL_W + 1 : CW;
    localparam int RES_W   = PW + RW + COL_W + 1;
    localparam int LANES   = mf3_pkg::RES_LANES;
    localparam int DEPTH   = mf3_pkg::RES_DEPTH;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 2;
    localparam int RAM_W   = 2 * PW;

    // Configuration registers.
    logic [CW-1:0] fw_reg, fw_next;
    logic [CW-1:0] fh_reg, fh_next;

    // Position of the next input item.
    logic [RW-1:0]    row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;

    // Decode of the item at the input.
    logic             s_accept;
    logic [CW-1:0]    fw_eff;
    logic [CW-1:0]    fh_eff;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] fw_ext;
    logic             acc_last_col;
    logic             acc_last_row;
    logic             acc_interior;
    logic [LANES-1:0] acc_emit;

    // Filter stage registers.
    logic             s1_valid_reg;
    logic [LANES-1:0] s1_emit_reg;
    logic             s1_interior_reg;
    mf3_pkg::pix_t    s1_cur_reg;
    logic [RW-1:0]    s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;

    // Window: column c-1 (rows r-2, r-1, r), then column c-2.
    mf3_pkg::pix_t    win_reg [mf3_pkg::WIN_REGS];

    // Line store data and median network.
    logic [RAM_W-1:0] ram_rd;
    mf3_pkg::pix_t    up_pix;
    mf3_pkg::pix_t    lo_pix;
    mf3_pkg::pix_t    taps [mf3_pkg::WIN_TAPS];
    mf3_pkg::pix_t    med_pix;
    mf3_pkg::pix_t    lane0_pix;

    // Result queue.
    logic [LANES-1:0]            push_en;
    logic [LANES-1:0][RES_W-1:0] push_data;
    logic                        res_valid;
    logic [RES_W-1:0]            res_data;
    logic [CNT_W-1:0]            res_count;
    logic [SUM_W-1:0]            room_sum;
    mf3_pkg::pix_t               res_pix;

    // Configuration writes; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mf3_pkg::CFG_FRAME_WIDTH:  fw_next = cfg_data;
                mf3_pkg::CFG_FRAME_HEIGHT: fh_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= CW'(mf3_pkg::FW_RESET);
            fh_reg <= CW'(mf3_pkg::FH_RESET);
        end else begin
            fw_reg <= fw_next;
            fh_reg <= fh_next;
        end
    end

    // Input acceptance: leave room for the item in flight and three more results.
    assign room_sum = SUM_W'(res_count) + SUM_W'(s1_emit_reg[0] & s1_valid_reg)
                    + SUM_W'(s1_emit_reg[1] & s1_valid_reg)
                    + SUM_W'(s1_emit_reg[2] & s1_valid_reg) + SUM_W'(LANES);
    assign s_ready  = (room_sum <= SUM_W'(DEPTH));
    assign s_accept = s_valid && s_ready;

    // Frame geometry with the width and height held at the minimum of three.
    always_comb begin
        fw_eff  = (fw_reg < CW'(mf3_pkg::MIN_DIM)) ? CW'(mf3_pkg::MIN_DIM) : fw_reg;
        fh_eff  = (fh_reg < CW'(mf3_pkg::MIN_DIM)) ? CW'(mf3_pkg::MIN_DIM) : fh_reg;
        col_ext = CMP_W'(col_cnt_reg);
        fw_ext  = CMP_W'(fw_eff);
        acc_last_col = (col_cnt_reg >= COL_W'(MAX_WIDTH - 1))
                    || (col_ext + CMP_W'(1) >= fw_ext);
        acc_last_row = ({1'b0, row_cnt_reg} + (RW + 1)'(1) >= {1'b0, fh_eff});
        acc_interior = (row_cnt_reg >= RW'(2)) && (col_cnt_reg >= COL_W'(2))
                    && (col_ext < fw_ext) && (row_cnt_reg < fh_eff);
        acc_emit[0]  = (row_cnt_reg != '0) && (col_cnt_reg != '0);
        acc_emit[1]  = acc_last_col && (row_cnt_reg != '0);
        acc_emit[2]  = acc_last_row;
    end

    // Raster position counters.
    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (s_accept) begin
            if (acc_last_col) begin
                col_cnt_next = '0;
                row_cnt_next = acc_last_row ? '0 : row_cnt_reg + RW'(1);
            end else begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // Filter stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            s1_emit_reg     <= '0;
            s1_interior_reg <= 1'b0;
        end else begin
            s1_valid_reg    <= s_accept;
            s1_emit_reg     <= acc_emit;
            s1_interior_reg <= acc_interior;
        end
    end

    // Filter stage payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cur_reg <= {s_in_ch2, s_in_ch1, s_in_ch0};
            s1_row_reg <= row_cnt_reg;
            s1_col_reg <= col_cnt_reg;
        end
    end

    // Line stores: upper row (r-2) in the high half, lower row (r-1) in the low half.
    mf3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({lo_pix, s1_cur_reg}),
        .rd_en   (s_accept),
        .rd_addr (col_cnt_reg),
        .rd_data (ram_rd)
    );

    assign up_pix = ram_rd[RAM_W-1:PW];
    assign lo_pix = ram_rd[PW-1:0];

    // Window shift as each item leaves the filter stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mf3_pkg::WIN_REGS; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_valid_reg) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= up_pix;
            win_reg[1] <= lo_pix;
            win_reg[2] <= s1_cur_reg;
        end
    end

    // The nine taps of the 3x3 neighborhood.
    always_comb begin
        taps[0] = win_reg[3];
        taps[1] = win_reg[0];
        taps[2] = up_pix;
        taps[3] = win_reg[4];
        taps[4] = win_reg[1];
        taps[5] = lo_pix;
        taps[6] = win_reg[5];
        taps[7] = win_reg[2];
        taps[8] = s1_cur_reg;
    end

    // One median network per filtered channel; others pass the center value.
    for (genvar k = 0; k < mf3_pkg::PORT_CH; k++) begin : g_chan
        if (k < NUM_CHANNELS) begin : g_filt
            logic [mf3_pkg::WIN_TAPS-1:0][CHW-1:0] med_in;
            for (genvar i = 0; i < mf3_pkg::WIN_TAPS; i++) begin : g_tap
                assign med_in[i] = taps[i][k*CHW +: CHW];
            end
            mf3_median9 u_med (
                .win (med_in),
                .med (med_pix[k*CHW +: CHW])
            );
        end else begin : g_pass
            assign med_pix[k*CHW +: CHW] = win_reg[1][k*CHW +: CHW];
        end
    end

    assign lane0_pix = s1_interior_reg ? med_pix : win_reg[1];

    // Results of the item in the filter stage, in lane order.
    always_comb begin
        push_en      = s1_valid_reg ? s1_emit_reg : '0;
        push_data[0] = {lane0_pix, s1_row_reg - RW'(1), s1_col_reg - COL_W'(1),
                        !s1_emit_reg[1] && !s1_emit_reg[2]};
        push_data[1] = {lo_pix, s1_row_reg - RW'(1), s1_col_reg, !s1_emit_reg[2]};
        push_data[2] = {s1_cur_reg, s1_row_reg, s1_col_reg, 1'b1};
    end

    mf3_res_fifo #(
        .WIDTH (RES_W),
        .DEPTH (DEPTH),
        .LANES (LANES)
    ) u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_data (push_data),
        .pop       (m_ready),
        .out_valid (res_valid),
        .out_data  (res_data),
        .count     (res_count)
    );

    // Result channel.
    assign m_valid = res_valid;
    assign {res_pix, m_out_row, m_out_col, m_last_of_run} = res_data;
    assign m_out_ch0 = res_pix[CHW-1:0];
    assign m_out_ch1 = res_pix[2*CHW-1:CHW];
    assign m_out_ch2 = res_pix[3*CHW-1:2*CHW];

    // Checks.
    `MF3_ASSERT(a_queue_bound, res_count <= CNT_W'(DEPTH), "result queue overfilled")
    `MF3_ASSERT_IMP(a_room_on_accept, s_accept, room_sum <= SUM_W'(DEPTH), "no room for item")
    `MF3_ASSERT(a_col_range, col_cnt_reg <= COL_W'(MAX_WIDTH - 1), "column beyond line store")
    `MF3_ASSERT_NEXT(a_row_end, s_accept && acc_last_col, col_cnt_reg == '0, "row did not wrap")

endmodule

FILE: verif/tb_median_filter_3x3_stream.sv
// Self-checking testbench for the streaming 3x3 median filter.
module tb_median_filter_3x3_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int COL_W        = $clog2(MAX_W);
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 410;
    localparam int PLAN_LEN     = 29;

    typedef enum logic [0:0] {
        STEP_PIXEL,
        STEP_CONFIG
    } step_kind_t;

    // One row of the directed script: a pixel item or a register write.
    // Where known is set, every result caused by the item must equal px.
    typedef struct packed {
        step_kind_t            kind;
        cfg_reg_t              reg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        pix_t                  px;
        logic                  known;
    } plan_row_t;

    typedef struct {
        pix_t             px;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } px_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    chan_t                 s_in_ch0;
    chan_t                 s_in_ch1;
    chan_t                 s_in_ch2;
    logic                  m_valid;
    logic                  m_ready;
    chan_t                 m_out_ch0;
    chan_t                 m_out_ch1;
    chan_t                 m_out_ch2;
    logic [ROW_W-1:0]      m_out_row;
    logic [COL_W-1:0]      m_out_col;
    logic                  m_last_of_run;

    // Shadow of the filter: registers, line stores, window and position.
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pix_t                  upper_line [MAX_W];
    pix_t                  lower_line [MAX_W];
    pix_t                  win [WIN_REGS];
    int unsigned           row_pos;
    int unsigned           col_pos;

    px_result_t            filtered_q [$];
    int                    mismatch_cnt;
    int                    items_sent;

    // Directed script. The first frame is flat white and checked against
    // typed-in values; it also covers both registers written below range
    // and a column that lies past the new, narrower row. The second frame
    // starts at the largest settings, narrows mid-row and then shortens
    // mid-frame so that its fourth row counts as the last one.
    plan_row_t plan [PLAN_LEN] = '{
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_CONFIG, CFG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b0},
        '{STEP_CONFIG, CFG_FRAME_HEIGHT, 12'd0,    24'h000000, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b1},
        '{STEP_CONFIG, CFG_FRAME_WIDTH,  12'd4095, 24'h000000, 1'b0},
        '{STEP_CONFIG, CFG_FRAME_HEIGHT, 12'd4095, 24'h000000, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFF00FF, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h00FF00, 1'b0},
        '{STEP_CONFIG, CFG_FRAME_WIDTH,  12'd3,    24'h000000, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h017F80, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h7F80FE, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h000000, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFFFFFF, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h123456, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hFEDCBA, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h01FF80, 1'b0},
        '{STEP_CONFIG, CFG_FRAME_HEIGHT, 12'd3,    24'h000000, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'hA5A5A5, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h5A5A5A, 1'b0},
        '{STEP_PIXEL,  CFG_FRAME_WIDTH,  12'd0,    24'h0F0F0F, 1'b0}
    };

    median_filter_3x3_stream #(
        .MAX_WIDTH    (MAX_W),
        .NUM_CHANNELS (PORT_CH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_ch0      (s_in_ch0),
        .s_in_ch1      (s_in_ch1),
        .s_in_ch2      (s_in_ch2),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_ch0     (m_out_ch0),
        .m_out_ch1     (m_out_ch1),
        .m_out_ch2     (m_out_ch2),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_last_of_run (m_last_of_run)
    );

    // Clock with a 2 ns period.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Each channel is mostly uniform, with its extremes weighted up.
    function automatic pix_t random_pixel();
        pix_t px;
        for (int k = 0; k < PORT_CH; k++) begin
            case ($urandom_range(0, 7))
                0: px[k*CH_W +: CH_W] = '0;
                1: px[k*CH_W +: CH_W] = '1;
                default: px[k*CH_W +: CH_W] = chan_t'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    // The value whose rank among the nine is the fifth.
    function automatic chan_t median_of_nine(input chan_t v [WIN_TAPS]);
        int below;
        int not_above;
        for (int i = 0; i < WIN_TAPS; i++) begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < WIN_TAPS; j++) begin
                if (v[j] < v[i]) below++;
                if (v[j] <= v[i]) not_above++;
            end
            if (below <= WIN_TAPS / 2 && not_above > WIN_TAPS / 2) return v[i];
        end
        return v[0];
    endfunction

    function automatic px_result_t make_result(input pix_t px, input int unsigned r,
                                               input int unsigned c);
        px_result_t res;
        res.px   = px;
        res.row  = ROW_W'(r);
        res.col  = COL_W'(c);
        res.last = 1'b0;
        return res;
    endfunction

    // Works out the results of one accepted pixel and advances the shadow.
    // With known set, the pixel value of every result is taken from px.
    task automatic filter_step(input pix_t cur, input bit known);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        pix_t        up;
        pix_t        lo;
        pix_t        pix;
        pix_t        taps [WIN_TAPS];
        chan_t       vals [WIN_TAPS];
        bit          last_col;
        bit          last_row;
        px_result_t  fresh [RES_LANES];
        int          n;

        w = width_reg;
        h = height_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_W) w = MAX_W;
        if (h < MIN_DIM) h = MIN_DIM;
        r = row_pos;
        c = col_pos;
        if (c >= MAX_W) c = MAX_W - 1;
        up = upper_line[c];
        lo = lower_line[c];
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        n = 0;

        // The pixel one up and one left: median inside the frame, else itself.
        if (r >= 1 && c >= 1) begin
            pix = win[1];
            if (r >= 2 && c >= 2 && c <= w - 1 && r <= h - 1) begin
                taps = '{win[3], win[0], up, win[4], win[1], lo, win[5], win[2], cur};
                for (int k = 0; k < PORT_CH; k++) begin
                    for (int i = 0; i < WIN_TAPS; i++) vals[i] = taps[i][k*CH_W +: CH_W];
                    pix[k*CH_W +: CH_W] = median_of_nine(vals);
                end
            end
            fresh[n] = make_result(pix, r - 1, c - 1);
            n++;
        end
        // The end of a row flushes the last column of the row above.
        if (last_col && r >= 1) begin
            fresh[n] = make_result(lo, r - 1, c);
            n++;
        end
        // On the last row each pixel is also border and goes out directly.
        if (last_row) begin
            fresh[n] = make_result(cur, r, c);
            n++;
        end
        if (n > 0) fresh[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (known) fresh[i].px = cur;
            filtered_q.push_back(fresh[i]);
        end

        // Shift the line stores and the window.
        upper_line[c] = lo;
        lower_line[c] = cur;
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = up;
        win[1] = lo;
        win[2] = cur;

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // Offers a pixel item after a random idle unless no_gaps; waits until taken.
    task automatic send_pixel(input pix_t px, input bit known, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_in_ch0 <= px[0*CH_W +: CH_W];
        s_in_ch1 <= px[1*CH_W +: CH_W];
        s_in_ch2 <= px[2*CH_W +: CH_W];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filter_step(px, known);
        items_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  width_reg = val;
            CFG_FRAME_HEIGHT: height_reg = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Stops input, waits for every expected result and lets the pipeline empty,
    // since items on the first row leave nothing behind to wait for.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result receiver: ready in runs of random length with random stalls.
    initial begin : sink_pacing
        int span;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (span) @(posedge aclk);
            span = idle_span();
            if (span > 0) begin
                m_ready <= 1'b0;
                repeat (span) @(posedge aclk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        px_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                note_mismatch($sformatf("result at row %0d col %0d with none expected",
                                        m_out_row, m_out_col));
            end else begin
                want = filtered_q.pop_front();
                if (m_out_ch0 !== want.px[0*CH_W +: CH_W])
                    note_mismatch($sformatf("ch0 %h, want %h at row %0d col %0d", m_out_ch0,
                                            want.px[0*CH_W +: CH_W], want.row, want.col));
                if (m_out_ch1 !== want.px[1*CH_W +: CH_W])
                    note_mismatch($sformatf("ch1 %h, want %h at row %0d col %0d", m_out_ch1,
                                            want.px[1*CH_W +: CH_W], want.row, want.col));
                if (m_out_ch2 !== want.px[2*CH_W +: CH_W])
                    note_mismatch($sformatf("ch2 %h, want %h at row %0d col %0d", m_out_ch2,
                                            want.px[2*CH_W +: CH_W], want.row, want.col));
                if (m_out_row !== want.row)
                    note_mismatch($sformatf("row %0d, want %0d", m_out_row, want.row));
                if (m_out_col !== want.col)
                    note_mismatch($sformatf("col %0d, want %0d", m_out_col, want.col));
                if (m_last_of_run !== want.last)
                    note_mismatch($sformatf("last_of_run %b, want %b at row %0d col %0d",
                                            m_last_of_run, want.last, want.row, want.col));
            end
        end
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("median_filter_3x3_stream: mismatch");
        $finish;
    end

    initial begin : stimulus
        int unsigned eff_w;
        int unsigned phase_len;
        bit          no_gaps;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_in_ch0  <= '0;
        s_in_ch1  <= '0;
        s_in_ch2  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= '0;
        mismatch_cnt = 0;
        items_sent   = 0;

        // Shadow state after reset.
        width_reg  = CFG_DATA_W'(FW_RESET);
        height_reg = CFG_DATA_W'(FH_RESET);
        for (int i = 0; i < MAX_W; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < WIN_REGS; i++) win[i] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed script.
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == STEP_CONFIG) begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].cfg_val);
            end else begin
                send_pixel(plan[i].px, plan[i].known, 1'b0);
            end
        end

        // Random phases of frames, often cut off mid-frame and resized.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            drain_results();
            eff_w = width_reg;
            if (eff_w < MIN_DIM) eff_w = MIN_DIM;
            if (eff_w > MAX_W) eff_w = MAX_W;
            if (row_pos == 0 && col_pos == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(0, 4095)));
                    1, 2:    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(9, 48)));
                    default: write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(3, 8)));
                endcase
                if ($urandom_range(0, 9) == 0)
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 4095)));
                else
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(3, 6)));
            end else begin
                // Mid-frame the width never grows, so every line store entry
                // read later was written earlier in this frame.
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_FRAME_WIDTH,
                              CFG_DATA_W'($urandom_range(0, eff_w < 12 ? eff_w : 12)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
            end
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(8, 60);
            for (int i = 0; i < phase_len; i++) send_pixel(random_pixel(), 1'b0, no_gaps);
        end

        drain_results();
        if (mismatch_cnt == 0) begin
            $display("median_filter_3x3_stream: match");
        end else begin
            $display("median_filter_3x3_stream: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/mf3_pkg.sv
src/mf3_ram.sv
src/mf3_median9.sv
src/mf3_res_fifo.sv
src/median_filter_3x3_stream.sv
verif/tb_median_filter_3x3_stream.sv
